### sv/tfb_pkg.sv
// Shared types, constants and helper functions of the temporal frame blender.
// Used by temporal_frame_blend, tfb_mix and tfb_checker; depends on nothing else.

package tfb_pkg;

  localparam int unsigned MAX_FRAME_PIXELS_DEF = 65536;
  localparam int unsigned FACTOR_SCALE_DEF     = 1000;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned FACTOR_W   = 10;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned DIM_MAX    = 256;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned TOTAL_W    = 17;
  localparam int unsigned TOTAL_MAX  = DIM_MAX * DIM_MAX;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned MAG_W      = CH_W + FACTOR_W;
  localparam int unsigned PIPE_DEPTH = 4;

  localparam logic [CH_W-1:0] LIGHT_THRESHOLD = CH_W'(255 / 2);

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE  = 2'd0,
    MODE_ALL   = 2'd1,
    MODE_LIGHT = 2'd2,
    MODE_DARK  = 2'd3
  } blend_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_MODE   = 2'd0,
    REG_BLEND_FACTOR = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_t;

  // Pipeline control handed to the arithmetic lanes.
  typedef struct packed {
    logic advance;
  } mix_ctrl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    begin
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(DIM_MAX)) r = DIM_W'(DIM_MAX);
      return r;
    end
  endfunction

  function automatic logic pixel_is_light(input logic [PIX_W-1:0] p);
    begin
      return (p[23:16] > LIGHT_THRESHOLD) || (p[15:8] > LIGHT_THRESHOLD) ||
             (p[7:0] > LIGHT_THRESHOLD);
    end
  endfunction

endpackage

### sv/tfb_mix.sv
// Per-channel blend arithmetic: (old - new) * factor, divide by the scale, add back.
// Its registers all move under one advance enable; depends on tfb_pkg.

module tfb_mix #(
  parameter int unsigned FACTOR_SCALE = tfb_pkg::FACTOR_SCALE_DEF
) (
  input  logic                           clk,
  input  tfb_pkg::mix_ctrl_t             ctrl,
  input  logic [tfb_pkg::PIX_W-1:0]      old_pixel,
  input  logic [tfb_pkg::PIX_W-1:0]      new_pixel,
  input  logic [tfb_pkg::FACTOR_W-1:0]   factor,
  output logic [tfb_pkg::PIX_W-1:0]      mixed_pixel
);

  localparam int unsigned CH_W   = tfb_pkg::CH_W;
  localparam int unsigned MAG_W  = tfb_pkg::MAG_W;
  localparam int unsigned L_W    = (FACTOR_SCALE > 1) ? $clog2(FACTOR_SCALE) : 1;
  localparam int unsigned SH     = MAG_W + L_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(FACTOR_SCALE) - 64'd1) / 64'(FACTOR_SCALE);
  localparam int unsigned REC_W  = MAG_W + 2;
  localparam int unsigned PROD_W = MAG_W + REC_W;

  localparam logic [REC_W-1:0] RECIP_C = REC_W'(RECIP);

  logic [tfb_pkg::PIX_W-1:0] new2_r;
  logic [tfb_pkg::PIX_W-1:0] new3_r;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      new2_r <= new_pixel;
      new3_r <= new2_r;
    end
  end

  for (genvar c = 0; c < tfb_pkg::NUM_CH; c++) begin : g_lane
    logic signed [CH_W:0]    diff;
    logic signed [MAG_W+1:0] prod_full;
    logic signed [MAG_W:0]   prod_r;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       scaled;
    logic [CH_W-1:0]         quot_r;
    logic                    neg_r;
    logic signed [CH_W+1:0]  sum;

    assign diff      = $signed({1'b0, old_pixel[c*CH_W +: CH_W]}) -
                       $signed({1'b0, new_pixel[c*CH_W +: CH_W]});
    assign prod_full = diff * $signed({1'b0, factor});

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign neg    = prod_r[MAG_W];
    assign mag    = neg ? MAG_W'(-prod_r) : MAG_W'(prod_r);
    assign scaled = PROD_W'(mag) * PROD_W'(RECIP_C);

    always_ff @(posedge clk) begin
      if (ctrl.advance) begin
        prod_r <= (MAG_W+1)'(prod_full);
        quot_r <= CH_W'(scaled >> SH);
        neg_r  <= neg;
      end
    end

    assign sum = neg_r ? ($signed({2'b00, new3_r[c*CH_W +: CH_W]}) - $signed({2'b00, quot_r}))
                       : ($signed({2'b00, new3_r[c*CH_W +: CH_W]}) + $signed({2'b00, quot_r}));

    assign mixed_pixel[c*CH_W +: CH_W] = sum[CH_W+1] ? '0 :
                                         (sum[CH_W] ? '1 : sum[CH_W-1:0]);
  end

endmodule

### sv/temporal_frame_blend.sv
// Top level of the temporal frame blender: frame memory, position tracking and pipeline.
// Depends on tfb_pkg and tfb_mix.
//
//   channel   direction  handshake            beat contents
//   in_*      input      in_valid / in_stall   new pixel, start of frame
//   out_*     output     out_valid / out_stall blended pixel, end of frame
//   cfg_*     input      cfg_wr_en             register index, write data
//
// The block takes one pixel per cycle unless a stall or the hold below stops the input. A
// result passes stages 1, 2 and 3, then the output register. The rate is set by the single
// frame memory, which gives one read and one write port per cycle. When a pixel reads
// a position that an earlier pixel still in flight has yet to write back (frames of
// three pixels or fewer, or a start of frame close behind another), the input is held
// until that write lands. Reset is synchronous and clears the control state only; the
// frame memory is not cleared, since blending starts only after a full frame has been
// written. A stall on a held result freezes the whole pipeline, and the input with it.

module temporal_frame_blend #(
  parameter int unsigned MAX_FRAME_PIXELS = tfb_pkg::MAX_FRAME_PIXELS_DEF,
  parameter int unsigned FACTOR_SCALE     = tfb_pkg::FACTOR_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tfb_pkg::PIX_W-1:0]         in_new_pixel,
  input  logic                              in_start_of_frame,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tfb_pkg::PIX_W-1:0]         out_pixel,
  output logic                              out_end_of_frame,
  input  logic                              cfg_wr_en,
  input  logic [tfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned ADDR_W  = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
  localparam int unsigned PIX_W   = tfb_pkg::PIX_W;
  localparam int unsigned POS_W   = tfb_pkg::POS_W;
  localparam int unsigned TOTAL_W = tfb_pkg::TOTAL_W;
  localparam int unsigned DIM_W   = tfb_pkg::DIM_W;
  localparam int unsigned FACT_W  = tfb_pkg::FACTOR_W;

  // A frame never holds more than the memory or the largest legal size.
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = (MAX_FRAME_PIXELS < tfb_pkg::TOTAL_MAX) ?
    TOTAL_W'(MAX_FRAME_PIXELS) : TOTAL_W'(tfb_pkg::TOTAL_MAX);
  localparam logic [FACT_W-1:0] FACTOR_CAP = (FACTOR_SCALE < ((1 << FACT_W) - 1)) ?
    FACT_W'(FACTOR_SCALE) : '1;

  // Configuration registers and frame bookkeeping.
  tfb_pkg::blend_mode_t  blend_mode_r;
  logic [FACT_W-1:0]     blend_factor_r;
  logic [DIM_W-1:0]      frame_width_r;
  logic [DIM_W-1:0]      frame_height_r;
  logic [TOTAL_W-1:0]    total_r, total_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  history_r, history_nxt;

  // Pipeline: stage 1 holds the memory read, stages 2 and 3 the arithmetic,
  // then the output register.
  logic                  s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic [ADDR_W-1:0]     s1_addr_r, s2_addr_r, s3_addr_r;
  logic [PIX_W-1:0]      s1_new_r, s2_new_r, s3_new_r;
  logic                  s1_blend_r, s2_blend_r, s3_blend_r;
  logic                  s1_last_r, s2_last_r, s3_last_r;
  logic [PIX_W-1:0]      out_pixel_r;
  logic                  out_eof_r;

  logic [PIX_W-1:0]      frame_mem [MAX_FRAME_PIXELS];
  logic [PIX_W-1:0]      mem_rdata_r;

  logic [FACT_W-1:0]     factor_eff;
  logic [POS_W-1:0]      pos_base, pos_in;
  logic                  last_in, blend_in, mode_hit, hazard, advance, accept;
  logic [ADDR_W-1:0]     addr_in;
  logic [PIX_W-1:0]      mixed_pixel, result;
  logic [DIM_W-1:0]      dim_w, dim_h;
  logic [TOTAL_W-1:0]    area;
  tfb_pkg::mix_ctrl_t    mix_ctrl;

  assign factor_eff = (blend_factor_r > FACTOR_CAP) ? FACTOR_CAP : blend_factor_r;

  // The whole pipeline moves whenever the output register can take a beat.
  assign advance = !out_valid_r || !out_stall;

  // Position of the incoming pixel; a start of frame restarts the count.
  assign pos_base = in_start_of_frame ? '0 : pos_r;
  assign pos_in   = ({1'b0, pos_base} >= total_r) ? '0 : pos_base;
  assign last_in  = (({1'b0, pos_in} + TOTAL_W'(1)) == total_r);
  assign addr_in  = ADDR_W'(pos_in);

  always_comb begin
    case (blend_mode_r)
      tfb_pkg::MODE_ALL:   mode_hit = 1'b1;
      tfb_pkg::MODE_LIGHT: mode_hit = tfb_pkg::pixel_is_light(in_new_pixel);
      tfb_pkg::MODE_DARK:  mode_hit = !tfb_pkg::pixel_is_light(in_new_pixel);
      default:             mode_hit = 1'b0;
    endcase
  end
  assign blend_in = mode_hit && (factor_eff != '0) && history_r;

  // Interlock: a pixel may not read a position whose write-back is still in flight.
  assign hazard = (s1_valid_r && (s1_addr_r == addr_in)) ||
                  (s2_valid_r && (s2_addr_r == addr_in)) ||
                  (s3_valid_r && (s3_addr_r == addr_in));

  assign in_stall = !advance || hazard;
  assign accept   = in_valid && !in_stall;

  // Frame size is recomputed when a dimension is written, so the pixel count
  // is ready for the next beat.
  assign dim_w = tfb_pkg::clamp_dim((cfg_index == tfb_pkg::REG_FRAME_WIDTH) ?
                                    cfg_data[DIM_W-1:0] : frame_width_r);
  assign dim_h = tfb_pkg::clamp_dim((cfg_index == tfb_pkg::REG_FRAME_HEIGHT) ?
                                    cfg_data[DIM_W-1:0] : frame_height_r);
  assign area  = TOTAL_W'(dim_w) * TOTAL_W'(dim_h);

  always_comb begin
    total_nxt   = total_r;
    pos_nxt     = pos_r;
    history_nxt = history_r;
    if (cfg_wr_en && ((cfg_index == tfb_pkg::REG_FRAME_WIDTH) ||
                      (cfg_index == tfb_pkg::REG_FRAME_HEIGHT))) begin
      total_nxt   = (area > TOTAL_CAP) ? TOTAL_CAP : area;
      pos_nxt     = '0;
      history_nxt = 1'b0;
    end else if (accept) begin
      if (last_in) begin
        pos_nxt     = '0;
        history_nxt = 1'b1;
      end else begin
        pos_nxt = pos_in + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r   <= tfb_pkg::MODE_NONE;
      blend_factor_r <= '0;
      frame_width_r  <= DIM_W'(tfb_pkg::DIM_MAX);
      frame_height_r <= DIM_W'(tfb_pkg::DIM_MAX);
      total_r        <= TOTAL_CAP;
      pos_r          <= '0;
      history_r      <= 1'b0;
    end else begin
      total_r   <= total_nxt;
      pos_r     <= pos_nxt;
      history_r <= history_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          tfb_pkg::REG_BLEND_MODE:   blend_mode_r   <= tfb_pkg::blend_mode_t'(cfg_data[1:0]);
          tfb_pkg::REG_BLEND_FACTOR: blend_factor_r <= cfg_data[FACT_W-1:0];
          tfb_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_W-1:0];
          tfb_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_addr_r   <= addr_in;
      s1_new_r    <= in_new_pixel;
      s1_blend_r  <= blend_in;
      s1_last_r   <= last_in;
      s2_addr_r   <= s1_addr_r;
      s2_new_r    <= s1_new_r;
      s2_blend_r  <= s1_blend_r;
      s2_last_r   <= s1_last_r;
      s3_addr_r   <= s2_addr_r;
      s3_new_r    <= s2_new_r;
      s3_blend_r  <= s2_blend_r;
      s3_last_r   <= s2_last_r;
      out_pixel_r <= result;
      out_eof_r   <= s3_last_r;
    end
  end

  // Frame memory: read when a pixel is taken, written as its result leaves stage 3.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_rdata_r <= frame_mem[addr_in];
    end
    if (advance && s3_valid_r) begin
      frame_mem[s3_addr_r] <= result;
    end
  end

  assign mix_ctrl.advance = advance;

  tfb_mix #(
    .FACTOR_SCALE (FACTOR_SCALE)
  ) u_mix (
    .clk         (clk),
    .ctrl        (mix_ctrl),
    .old_pixel   (mem_rdata_r),
    .new_pixel   (s1_new_r),
    .factor      (factor_eff),
    .mixed_pixel (mixed_pixel)
  );

  assign result = s3_blend_r ? mixed_pixel : s3_new_r;

  assign out_valid        = out_valid_r;
  assign out_pixel        = out_pixel_r;
  assign out_end_of_frame = out_eof_r;

endmodule

### sv/tfb_checker.sv
// Port-level checks for temporal_frame_blend, attached to it by the bind below.
// Depends on tfb_pkg.

module tfb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tfb_pkg::PIX_W-1:0]     out_pixel,
  input logic                          out_end_of_frame
);

  localparam int unsigned CNT_W = 3;

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] pending_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // Never more beats in flight than pipeline stages.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= CNT_W'(tfb_pkg::PIPE_DEPTH))
    else $error("more beats in flight than pipeline stages");

  // A result is shown only for a beat that was taken.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != '0))
    else $error("result without a pending input beat");

  // Into an empty block, a taken beat reaches the output without being held up.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (pending_r == '0)) |-> ##4 out_valid)
    else $error("result missing after pipeline latency");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pixel) &&
                                  $stable(out_end_of_frame)))
    else $error("stalled result changed");

endmodule

bind temporal_frame_blend tfb_checker u_tfb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel        (out_pixel),
  .out_end_of_frame (out_end_of_frame)
);

### test/temporal_frame_blend_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for temporal_frame_blend: a scoreboard class predicts every
// blended pixel while plain tasks drive pixel, result and register traffic. Depends on tfb_pkg.

module temporal_frame_blend_tb;

  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no beat or write before giving up
  localparam int unsigned HOLD_CYCLES = 300;   // length of the long receiver hold-off
  localparam int unsigned PIXEL_GOAL  = 1550;

  localparam int unsigned PIX_W            = tfb_pkg::PIX_W;
  localparam int unsigned CH_W             = tfb_pkg::CH_W;
  localparam int unsigned NUM_CH           = tfb_pkg::NUM_CH;
  localparam int unsigned FACTOR_W         = tfb_pkg::FACTOR_W;
  localparam int unsigned MODE_W           = tfb_pkg::MODE_W;
  localparam int unsigned DIM_W            = tfb_pkg::DIM_W;
  localparam int unsigned DIM_MAX          = tfb_pkg::DIM_MAX;
  localparam int unsigned CFG_DATA_W       = tfb_pkg::CFG_DATA_W;
  localparam int unsigned FACTOR_SCALE_DEF = tfb_pkg::FACTOR_SCALE_DEF;
  localparam int unsigned PIPE_DEPTH       = tfb_pkg::PIPE_DEPTH;

  // The scoreboard keeps its own copy of the registers, the frame memory, the history
  // flag and the raster position. Each accepted input beat yields exactly one expected
  // result, queued in order; each output beat is matched against the oldest one.
  class frame_blend_board;
    typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             last;
    } blended_t;

    blended_t             awaited[$];
    int unsigned          mismatches;
    tfb_pkg::blend_mode_t mode;
    logic [FACTOR_W-1:0]  factor;
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    bit [PIX_W-1:0]       shown_frame[tfb_pkg::MAX_FRAME_PIXELS_DEF];
    bit                   history;
    int unsigned          position;

    function new();
      mismatches = 0;
      mode       = tfb_pkg::MODE_NONE;
      factor     = '0;
      width      = DIM_W'(DIM_MAX);
      height     = DIM_W'(DIM_MAX);
      history    = 1'b0;
      position   = 0;
    endfunction

    // A size of zero behaves as one; anything from 256 up behaves as 256.
    function int unsigned usable(logic [DIM_W-1:0] v);
      return (v == '0) ? 1 : (v[DIM_W-1] ? DIM_MAX : int'(v));
    endfunction

    function int unsigned frame_span();
      return usable(width) * usable(height);
    endfunction

    function void write_reg(tfb_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        tfb_pkg::REG_BLEND_MODE:   mode = tfb_pkg::blend_mode_t'(val[MODE_W-1:0]);
        tfb_pkg::REG_BLEND_FACTOR: factor = val[FACTOR_W-1:0];
        tfb_pkg::REG_FRAME_WIDTH: begin
          width    = val[DIM_W-1:0];
          history  = 1'b0;
          position = 0;
        end
        default: begin
          height   = val[DIM_W-1:0];
          history  = 1'b0;
          position = 0;
        end
      endcase
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic sof);
      int unsigned span, slot, weight;
      int          gap, step;
      bit          mixing, bright;
      blended_t    res;
      span = frame_span();
      if (sof) position = 0;
      slot = (position >= span) ? 0 : position;
      weight = (factor > FACTOR_SCALE_DEF) ? FACTOR_SCALE_DEF : int'(factor);
      // A pixel counts as light when any of R, G or B reaches 128.
      bright = pix[23] | pix[15] | pix[7];
      case (mode)
        tfb_pkg::MODE_ALL:   mixing = 1'b1;
        tfb_pkg::MODE_LIGHT: mixing = bright;
        tfb_pkg::MODE_DARK:  mixing = !bright;
        default:             mixing = 1'b0;
      endcase
      if (weight == 0 || !history) mixing = 1'b0;
      res.pixel = pix;
      if (mixing) begin
        for (int c = 0; c < NUM_CH; c++) begin
          gap  = int'(shown_frame[slot][CH_W*c +: CH_W]) - int'(pix[CH_W*c +: CH_W]);
          step = (gap * int'(weight)) / int'(FACTOR_SCALE_DEF);  // truncates toward zero
          res.pixel[CH_W*c +: CH_W] = CH_W'(int'(pix[CH_W*c +: CH_W]) + step);
        end
      end
      shown_frame[slot] = res.pixel;
      res.last = (slot + 1 == span);
      if (res.last) begin
        history  = 1'b1;
        position = 0;
      end else begin
        position = slot + 1;
      end
      awaited.push_back(res);
    endfunction

    function void check_pixel(logic [PIX_W-1:0] pix, logic eof);
      blended_t want;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: out_pixel %h", pix);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (pix !== want.pixel) begin
        $error("out_pixel expected %h actual %h", want.pixel, pix);
        mismatches++;
      end
      if (eof !== want.last) begin
        $error("out_end_of_frame expected %b actual %b", want.last, eof);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_new_pixel = '0;
  logic                  in_start_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_pixel;
  logic                  out_end_of_frame;
  logic                  cfg_wr_en = 1'b0;
  tfb_pkg::cfg_reg_t     cfg_index = tfb_pkg::REG_BLEND_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_blend_board board = new();

  int unsigned idle_pct = 0;        // chance per cycle that the sender holds back
  int unsigned stall_pct = 0;       // chance per cycle that the receiver stalls
  bit          hold_request = 1'b0; // asks the receiver for one long hold-off
  int unsigned pixels_sent = 0;
  int unsigned quiet_cycles = 0;

  temporal_frame_blend uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_new_pixel      (in_new_pixel),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel         (out_pixel),
    .out_end_of_frame  (out_end_of_frame),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver. Outputs are sampled right after the edge, so they still hold the values
  // that the edge saw. The stall for the next edge is chosen once per cycle; a hold-off
  // request turns into a long run of stalled cycles counted down here.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_pixel(out_pixel, out_end_of_frame);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: any beat or register write counts as progress.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("temporal_frame_blend_tb: errors");
    $finish;
  end

  // Offers one pixel beat, possibly after a random gap, and returns at the edge that
  // took it. The caller either offers the next beat at once, keeping valid high, or
  // lowers valid in that same step; valid is never lowered and raised in one step.
  task automatic send_beat(logic [PIX_W-1:0] pix, logic sof);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_new_pixel      <= pix;
    in_start_of_frame <= sof;
    do @(posedge clk); while (in_stall);
    board.note_pixel(pix, sof);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty. Mode and factor are always
  // written; the frame size only when asked, since that throws the history away.
  task automatic program_regs(tfb_pkg::blend_mode_t mode, int unsigned factor, bit resize,
                              int unsigned w, int unsigned h);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= tfb_pkg::REG_BLEND_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    board.write_reg(tfb_pkg::REG_BLEND_MODE, CFG_DATA_W'(mode));
    cfg_index <= tfb_pkg::REG_BLEND_FACTOR;
    cfg_data  <= CFG_DATA_W'(factor);
    @(posedge clk);
    board.write_reg(tfb_pkg::REG_BLEND_FACTOR, CFG_DATA_W'(factor));
    if (resize) begin
      cfg_index <= tfb_pkg::REG_FRAME_WIDTH;
      cfg_data  <= CFG_DATA_W'(w);
      @(posedge clk);
      board.write_reg(tfb_pkg::REG_FRAME_WIDTH, CFG_DATA_W'(w));
      cfg_index <= tfb_pkg::REG_FRAME_HEIGHT;
      cfg_data  <= CFG_DATA_W'(h);
      @(posedge clk);
      board.write_reg(tfb_pkg::REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom & 32'hFF7F_7F7F;  // dark: every RGB channel below 128
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned random_factor();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return 0;
      1:       return FACTOR_SCALE_DEF;
      2:       return (1 << FACTOR_W) - 1;  // beyond full scale, acts as full scale
      3:       return 1;
      default: return $urandom_range(2, FACTOR_SCALE_DEF - 1);
    endcase
  endfunction

  // Mostly well-formed frames with start of frame on the first pixel. A few beats restart
  // the frame early, and a few frame starts go unmarked to lean on the position wrap.
  task automatic run_pixels(int unsigned count);
    int unsigned along, span, roll;
    logic        sof;
    along = 0;
    span  = board.frame_span();
    for (int unsigned k = 0; k < count; k++) begin
      sof  = (along == 0);
      roll = $urandom_range(99);
      if (roll < 4) sof = 1'b1;
      else if (roll < 7 && sof) sof = 1'b0;
      if (sof) along = 0;
      send_beat(random_pixel(), sof);
      along = (along + 1 == span) ? 0 : along + 1;
    end
    in_valid <= 1'b0;
  endtask

  task automatic set_idling(int unsigned style);
    case (style % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 75; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 75; end
      default: begin idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  initial begin
    int unsigned phase, span;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. With reset settings (256 x 256, no blending) pixels pass untouched,
    // including both sides of the light threshold.
    send_beat('1, 1'b1);
    send_beat('0, 1'b0);
    send_beat(32'h8080_8080, 1'b0);
    send_beat(32'h7F7F_7F7F, 1'b0);
    in_valid <= 1'b0;

    // Zero sizes act as one: single-pixel frames, each beat ends a frame and every pixel
    // reads back the one just written, which forces the read-after-write hold.
    program_regs(tfb_pkg::MODE_ALL, FACTOR_SCALE_DEF / 2, 1'b1, 0, 0);
    send_beat('0, 1'b1);
    send_beat('1, 1'b1);
    send_beat('0, 1'b0);
    send_beat(32'h0000_00FF, 1'b1);
    in_valid <= 1'b0;

    // Factor over full scale on two-pixel frames; light mode skips the dark pixels.
    program_regs(tfb_pkg::MODE_LIGHT, (1 << FACTOR_W) - 1, 1'b1, 1, 2);
    send_beat('1, 1'b1);
    send_beat('0, 1'b0);
    send_beat(32'h1234_5678, 1'b1);
    send_beat(32'h0080_0000, 1'b0);
    in_valid <= 1'b0;

    // Smallest non-zero factor in dark mode.
    program_regs(tfb_pkg::MODE_DARK, 1, 1'b1, 2, 1);
    send_beat(32'hFF00_0000, 1'b1);
    send_beat(32'h00FF_FFFF, 1'b0);
    send_beat(32'h007F_7F7F, 1'b1);
    send_beat(32'h0000_0080, 1'b0);
    in_valid <= 1'b0;

    // With history in place, mode none and a zero factor both still pass the pixel.
    program_regs(tfb_pkg::MODE_NONE, FACTOR_SCALE_DEF - 1, 1'b0, 0, 0);
    send_beat(32'hA5A5_A5A5, 1'b1);
    send_beat(32'h5A5A_5A5A, 1'b0);
    in_valid <= 1'b0;
    program_regs(tfb_pkg::MODE_ALL, 0, 1'b0, 0, 0);
    send_beat(32'h0102_0304, 1'b1);
    send_beat(32'hFEFD_FCFB, 1'b0);
    in_valid <= 1'b0;

    // Widest line (511 acts as 256) for two frames. The receiver holds off for a long
    // stretch while the sender keeps offering, so the pipeline fills and backs up.
    program_regs(tfb_pkg::MODE_ALL, random_factor(), 1'b1, (1 << DIM_W) - 1, 1);
    set_idling(0);
    hold_request = 1'b1;
    run_pixels(2 * board.frame_span());

    // Tallest frame (300 acts as 256) one column wide, a bit more than one frame.
    program_regs(tfb_pkg::MODE_LIGHT, FACTOR_SCALE_DEF, 1'b1, 0, 300);
    set_idling(3);
    run_pixels(board.frame_span() + 10);

    // Random phases on small frames, cycling through the idling styles. About half the
    // phases keep the frame size, so blending runs on history from earlier phases.
    phase = 0;
    while (pixels_sent < PIXEL_GOAL) begin
      set_idling(phase);
      if ($urandom_range(1) == 0)
        program_regs(tfb_pkg::blend_mode_t'($urandom_range(3)), random_factor(), 1'b0,
                     0, 0);
      else
        program_regs(tfb_pkg::blend_mode_t'($urandom_range(3)), random_factor(), 1'b1,
                     $urandom_range(1, 8), $urandom_range(1, 6));
      span = board.frame_span();
      run_pixels(span * $urandom_range(2, 4) + $urandom_range(0, 5));
      phase++;
    end

    wait_drained();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (board.mismatches == 0 && board.awaited.size() == 0)
      $display("temporal_frame_blend_tb: clean");
    else
      $display("temporal_frame_blend_tb: errors");
    $finish;
  end

endmodule

### files.f
sv/tfb_pkg.sv
sv/tfb_mix.sv
sv/temporal_frame_blend.sv
sv/tfb_checker.sv
test/temporal_frame_blend_tb.sv
